>>> hw/rtl/drcq_pkg.sv
// ----------------------------------------------------------------------------
// drcq_pkg
// Shared types and constants of the deferred release countdown queue.
// ----------------------------------------------------------------------------
package drcq_pkg;

   localparam int TABLE_DEPTH_DEF = 32;

   localparam int KIND_W   = 4;
   localparam int HANDLE_W = 64;
   localparam int ALLOC_W  = 64;
   localparam int DELAY_W  = 16;
   localparam int OP_W     = 2;

   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 136;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_BUF_ALLOC = 4'd13;
   localparam logic [KIND_W-1:0] KIND_IMG_ALLOC = 4'd14;

   localparam logic STATUS_RELEASED = 1'b0;
   localparam logic STATUS_FULL     = 1'b1;

   localparam logic [1:0] SEL_HOLD  = 2'd0;
   localparam logic [1:0] SEL_SHIFT = 2'd1;
   localparam logic [1:0] SEL_HEAD  = 2'd2;
   localparam logic [1:0] SEL_LOAD  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      logic [ALLOC_W-1:0]  alloc;
      logic [DELAY_W-1:0]  countdown;
   } entry_type;

   typedef struct packed {
      logic [1:0] sel;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/drcq_cell.sv
// ----------------------------------------------------------------------------
// drcq_cell
// One table slot: holds, takes its right neighbor, takes the recirculated
// head entry, or loads a new entry.
// ----------------------------------------------------------------------------
module drcq_cell
   import drcq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     next_entry,
   input  entry_type     head_entry,
   input  entry_type     load_entry,
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      case (ctrl.sel)
         SEL_SHIFT: entry_in = next_entry;
         SEL_HEAD:  entry_in = head_entry;
         SEL_LOAD:  entry_in = load_entry;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> hw/rtl/deferred_release_countdown_queue_unit.sv
// Insert: accepted back to back while the output is free; a rejected insert's
// result is visible the cycle after acceptance.
// Tick or flush: the head cell is examined once a cycle while the chain shifts,
// releases leave one per cycle, one step behind.
// Output stalls pause the pass. No new request while a pass runs.
// Reset empties the table at once; slot contents stay undefined until written.
// ----------------------------------------------------------------------------
// deferred_release_countdown_queue_unit
// Ordered table of pending releases kept in a chain of cells, with countdown
// on tick, in-order release, compaction and flush.
// ----------------------------------------------------------------------------
module deferred_release_countdown_queue_unit
   import drcq_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // object_kind[3:0], handle[67:4], alloc_tag[131:68], delay_frames[147:132]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // released_kind[3:0], released_handle[67:4], released_alloc[131:68]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic          state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          flush_ff, flush_in;
   logic          pend_valid_ff, pend_valid_in;
   entry_type     pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   entry_type     rsp_data_ff, rsp_data_in;
   logic          rsp_status_ff, rsp_status_in;
   logic          rsp_last_ff, rsp_last_in;

   entry_type     cells [TABLE_DEPTH];
   entry_type     head;
   entry_type     head_dec;
   entry_type     load_entry;
   entry_type     zero_entry;

   logic [KIND_W-1:0]   req_kind;
   logic [HANDLE_W-1:0] req_handle;
   logic [ALLOC_W-1:0]  req_alloc;
   logic [DELAY_W-1:0]  req_delay;

   logic out_free, accept, step, finish, survive, insert_ok, is_full;

   assign req_kind   = req_tdata[3:0];
   assign req_handle = req_tdata[67:4];
   assign req_alloc  = req_tdata[131:68];
   assign req_delay  = req_tdata[147:132];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CW'(TABLE_DEPTH));
   assign insert_ok  = accept && (req_tuser == OP_INSERT) &&
                       (req_handle != '0) && !is_full;
   assign step       = (state_ff == ST_RUN) && out_free && (remain_ff != '0);
   assign finish     = (state_ff == ST_RUN) && out_free && (remain_ff == '0);

   assign head     = cells[0];
   assign survive  = !flush_ff && (head.countdown != '0);
   assign zero_entry = '0;

   always_comb begin
      head_dec           = head;
      head_dec.countdown = head.countdown - DELAY_W'(1);
   end

   always_comb begin
      load_entry.kind      = req_kind;
      load_entry.handle    = req_handle;
      load_entry.alloc     = (req_kind inside {KIND_BUF_ALLOC, KIND_IMG_ALLOC})
                             ? req_alloc : '0;
      load_entry.countdown = req_delay;
   end

   // chain of slots, cell 0 is the head of the table
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      entry_type     next_entry;

      if (i == TABLE_DEPTH - 1) begin : g_end
         assign next_entry = zero_entry;
      end else begin : g_mid
         assign next_entry = cells[i+1];
      end

      always_comb begin
         ctrl.sel = SEL_HOLD;
         if (step) begin
            if (CW'(i + 1) < count_ff) begin
               ctrl.sel = SEL_SHIFT;
            end else if (CW'(i + 1) == count_ff && survive) begin
               ctrl.sel = SEL_HEAD;
            end
         end else if (insert_ok && CW'(i) == count_ff) begin
            ctrl.sel = SEL_LOAD;
         end
      end

      drcq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .next_entry (next_entry),
         .head_entry (head_dec),
         .load_entry (load_entry),
         .entry      (cells[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      flush_in      = flush_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (accept) begin
         case (req_tuser)
            OP_INSERT: begin
               if (req_handle != '0) begin
                  if (is_full) begin
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = STATUS_FULL;
                     rsp_last_in   = 1'b1;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
            end
            OP_TICK, OP_FLUSH: begin
               state_in  = ST_RUN;
               remain_in = count_ff;
               flush_in  = (req_tuser == OP_FLUSH);
            end
            default: ;
         endcase
      end

      if (step) begin
         remain_in = remain_ff - CW'(1);
         if (!survive) begin
            count_in      = count_ff - CW'(1);
            pend_valid_in = 1'b1;
            pend_in       = head;
            if (pend_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = pend_ff;
               rsp_status_in = STATUS_RELEASED;
               rsp_last_in   = 1'b0;
            end
         end
      end

      if (finish) begin
         state_in      = ST_IDLE;
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = pend_ff;
            rsp_status_in = STATUS_RELEASED;
            rsp_last_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         remain_ff     <= '0;
         flush_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         remain_ff     <= remain_in;
         flush_ff      <= flush_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff.alloc, rsp_data_ff.handle, rsp_data_ff.kind};

endmodule

>>> tb/drcq_release_monitor.sv
// ----------------------------------------------------------------------------
// drcq_release_monitor
// Watches the request and release channels of the deferred release countdown
// queue, keeps its own copy of the pending release table, works out which
// releases each accepted request must cause and checks every accepted release
// against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module drcq_release_monitor
   import drcq_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   output int                    error_count,
   output int                    pending_count
);

   typedef struct packed {
      logic                status;
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      logic [ALLOC_W-1:0]  alloc;
      logic                last;
   } release_type;

   entry_type   table_slots [TABLE_DEPTH];
   int          occupancy = 0;
   int          fail_total = 0;
   release_type due_releases [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("drcq_release_monitor: %s", msg);
      fail_total++;
   endtask

   function automatic release_type make_release(input logic status, input entry_type slot);
      release_type rel;
      rel.status = status;
      rel.kind   = slot.kind;
      rel.handle = slot.handle;
      rel.alloc  = slot.alloc;
      rel.last   = 1'b0;
      return rel;
   endfunction

   task automatic advance_release_table(input logic [OP_W-1:0] op, input entry_type item);
      int          kept;
      int          first_new;
      release_type rel;
      first_new = due_releases.size();
      case (op)
         OP_INSERT: begin
            if (item.handle != '0) begin
               if (occupancy >= TABLE_DEPTH) begin
                  due_releases.push_back(make_release(STATUS_FULL, '0));
               end else begin
                  table_slots[occupancy] = item;
                  occupancy++;
               end
            end
         end
         OP_TICK: begin
            kept = 0;
            for (int i = 0; i < occupancy; i++) begin
               if (table_slots[i].countdown == '0) begin
                  due_releases.push_back(make_release(STATUS_RELEASED, table_slots[i]));
               end else begin
                  table_slots[kept] = table_slots[i];
                  table_slots[kept].countdown = table_slots[i].countdown - 1'b1;
                  kept++;
               end
            end
            occupancy = kept;
         end
         OP_FLUSH: begin
            for (int i = 0; i < occupancy; i++) begin
               due_releases.push_back(make_release(STATUS_RELEASED, table_slots[i]));
            end
            occupancy = 0;
         end
         default: ;
      endcase
      if (due_releases.size() > first_new) begin
         rel = due_releases.pop_back();
         rel.last = 1'b1;
         due_releases.push_back(rel);
      end
   endtask

   always @(posedge clock) begin
      entry_type   item;
      release_type want;
      if (reset) begin
         occupancy = 0;
         due_releases.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_releases.size() == 0) begin
               report_mismatch($sformatf("unexpected release, handle %0h", rsp_tdata[67:4]));
            end else begin
               want = due_releases.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch($sformatf("status got %0h expected %0h",
                                            rsp_tuser, want.status));
               if (rsp_tdata[3:0] !== want.kind)
                  report_mismatch($sformatf("kind got %0h expected %0h",
                                            rsp_tdata[3:0], want.kind));
               if (rsp_tdata[67:4] !== want.handle)
                  report_mismatch($sformatf("handle got %0h expected %0h",
                                            rsp_tdata[67:4], want.handle));
               if (rsp_tdata[131:68] !== want.alloc)
                  report_mismatch($sformatf("alloc got %0h expected %0h",
                                            rsp_tdata[131:68], want.alloc));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last got %0h expected %0h",
                                            rsp_tlast, want.last));
            end
         end
         if (req_tvalid && req_tready) begin
            item.kind      = req_tdata[3:0];
            item.handle    = req_tdata[67:4];
            item.countdown = req_tdata[147:132];
            item.alloc     = (item.kind == KIND_BUF_ALLOC || item.kind == KIND_IMG_ALLOC) ?
                             req_tdata[131:68] : '0;
            advance_release_table(req_tuser, item);
         end
      end
      error_count   <= fail_total;
      pending_count <= due_releases.size();
   end

endmodule

>>> tb/tb_deferred_release_countdown_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_deferred_release_countdown_queue_unit
// Drives inserts, frame ticks and flushes into the release queue in random
// bursts while the release side stalls on its own pattern; a monitor beside
// the block predicts and checks every release and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_deferred_release_countdown_queue_unit;
   import drcq_pkg::*;

   localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
   localparam int IDLE_LIMIT     = 1000;
   localparam int DRAIN_CYCLES   = TABLE_DEPTH + 8;
   localparam int REQUEST_TARGET = 350;

   localparam logic [OP_W-1:0]     OP_UNUSED = 2'd3;
   localparam logic [KIND_W-1:0]   KIND_TOP  = 4'd15;
   localparam logic [HANDLE_W-1:0] ALL_ONES  = '1;
   localparam logic [DELAY_W-1:0]  DELAY_MAX = '1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = OP_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   int error_count;
   int pending_count;
   int burst_left       = 0;
   int counted_requests = 0;
   int idle_cycles      = 0;
   int stall_mode       = 0;
   int mode_left        = 0;

   always #5 clock = ~clock;

   deferred_release_countdown_queue_unit #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   drcq_release_monitor #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_release_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      if (mode_left == 0) begin
         mode_left  <= $urandom_range(16, 96);
         stall_mode <= $urandom_range(0, 2);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (mode_left % 6 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_deferred_release_countdown_queue_unit: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [HANDLE_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [HANDLE_W-1:0] random_handle();
      logic [HANDLE_W-1:0] h;
      case ($urandom_range(0, 7))
         0:       h = ALL_ONES;
         1:       h = 64'd1;
         default: h = random_word();
      endcase
      if (h == '0)
         h = 64'd1;
      return h;
   endfunction

   task automatic send_request(input logic [OP_W-1:0]     op,
                               input logic [KIND_W-1:0]   kind,
                               input logic [HANDLE_W-1:0] handle,
                               input logic [ALLOC_W-1:0]  tag,
                               input logic [DELAY_W-1:0]  delay);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) :
                                                    $urandom_range(1, 10);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, delay, tag, handle, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!((op == OP_INSERT && handle == '0) || op == OP_UNUSED))
         counted_requests++;
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic send_insert(input logic [DELAY_W-1:0] delay);
      send_request(OP_INSERT, KIND_W'($urandom_range(0, 15)), random_handle(),
                   random_word(), delay);
   endtask

   task automatic send_tick();
      send_request(OP_TICK, KIND_W'($urandom_range(0, 15)), random_word(), random_word(),
                   DELAY_W'($urandom_range(0, 65535)));
   endtask

   task automatic send_flush();
      send_request(OP_FLUSH, KIND_W'($urandom_range(0, 15)), random_word(), random_word(),
                   DELAY_W'($urandom_range(0, 65535)));
   endtask

   // overfill, then a zero handle against the full table, then drain
   task automatic fill_table();
      repeat (TABLE_DEPTH + $urandom_range(1, 3))
         send_insert(DELAY_W'($urandom_range(0, 6)));
      send_request(OP_INSERT, KIND_W'($urandom_range(0, 15)), '0, random_word(),
                   DELAY_W'($urandom_range(0, 6)));
      repeat ($urandom_range(0, 4)) send_tick();
      send_flush();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_INSERT, 4'd0, ALL_ONES, ALL_ONES, '0);
      send_request(OP_INSERT, KIND_BUF_ALLOC, 64'd1, ALL_ONES, '0);
      send_request(OP_INSERT, KIND_IMG_ALLOC, 64'hA5A5_A5A5_A5A5_A5A5,
                   64'h5A5A_5A5A_5A5A_5A5A, 16'd1);
      send_request(OP_INSERT, KIND_TOP, 64'h0123_4567_89AB_CDEF, ALL_ONES, 16'd2);
      send_request(OP_INSERT, 4'd12, 64'h8000_0000_0000_0000, ALL_ONES, DELAY_MAX);
      send_request(OP_INSERT, KIND_BUF_ALLOC, '0, ALL_ONES, '0);
      send_request(OP_UNUSED, KIND_TOP, ALL_ONES, ALL_ONES, DELAY_MAX);
      send_request(OP_TICK, '0, '0, '0, '0);
      send_request(OP_TICK, '0, '0, '0, '0);
      send_request(OP_TICK, '0, '0, '0, '0);
      send_request(OP_TICK, '0, '0, '0, '0);
      send_request(OP_FLUSH, '0, '0, '0, '0);
      send_request(OP_TICK, KIND_TOP, ALL_ONES, ALL_ONES, DELAY_MAX);
      send_request(OP_FLUSH, KIND_TOP, ALL_ONES, ALL_ONES, DELAY_MAX);
      wait_until_drained();

      fill_table();
      while (counted_requests < REQUEST_TARGET) begin
         case ($urandom_range(0, 9))
            0: fill_table();
            1, 2: begin
               repeat ($urandom_range(4, 10)) begin
                  send_request(OP_W'($urandom_range(0, 3)), KIND_W'($urandom_range(0, 15)),
                               ($urandom_range(0, 3) == 0) ? '0 : random_word(),
                               random_word(), DELAY_W'($urandom_range(0, 65535)));
               end
            end
            3: send_flush();
            default: begin
               repeat ($urandom_range(1, 8)) send_insert(DELAY_W'($urandom_range(0, 4)));
               repeat ($urandom_range(1, 5)) send_tick();
            end
         endcase
         if ($urandom_range(0, 7) == 0)
            wait_until_drained();
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb_deferred_release_countdown_queue_unit: done, clean");
      end else begin
         $display("tb_deferred_release_countdown_queue_unit: done, errors");
      end
      $finish;
   end

endmodule
